// ===== hw/rtl/c2s_pkg.sv =====
// shared types, constants and the arctangent table of the cartesian to spherical unit
// used by every rtl file of the block, depends on nothing
package c2s_pkg;

    localparam int CORDIC_STAGES = 16;
    localparam int ANGLE_TABLE_SIZE = 32;
    localparam int NUM_ROT = (CORDIC_STAGES < ANGLE_TABLE_SIZE) ? CORDIC_STAGES
                                                                : ANGLE_TABLE_SIZE;
    localparam int SQRT_STEPS = 16;
    localparam int CW = 36;
    localparam int LATENCY = 1 + SQRT_STEPS + NUM_ROT + 1;

    typedef struct packed {
        logic [31:0]          v;
        logic [31:0]          res;
        logic signed [CW-1:0] lx;
        logic signed [CW-1:0] ly;
        logic [31:0]          lacc;
        logic                 lzero;
        logic signed [16:0]   z;
    } t_sqrt_word;

    typedef struct packed {
        logic signed [CW-1:0] lx;
        logic signed [CW-1:0] ly;
        logic [31:0]          lacc;
        logic signed [CW-1:0] bx;
        logic signed [CW-1:0] by;
        logic [31:0]          bacc;
        logic                 lzero;
    } t_cordic_word;

    function automatic logic [31:0] atan_turn(input logic [4:0] idx);
        logic [31:0] a;
        case (idx)
            5'd0:  a = 32'd536870912;
            5'd1:  a = 32'd316933406;
            5'd2:  a = 32'd167458907;
            5'd3:  a = 32'd85004756;
            5'd4:  a = 32'd42667331;
            5'd5:  a = 32'd21354465;
            5'd6:  a = 32'd10679838;
            5'd7:  a = 32'd5340245;
            5'd8:  a = 32'd2670163;
            5'd9:  a = 32'd1335087;
            5'd10: a = 32'd667544;
            5'd11: a = 32'd333772;
            5'd12: a = 32'd166886;
            5'd13: a = 32'd83443;
            5'd14: a = 32'd41722;
            5'd15: a = 32'd20861;
            5'd16: a = 32'd10430;
            5'd17: a = 32'd5215;
            5'd18: a = 32'd2608;
            5'd19: a = 32'd1304;
            5'd20: a = 32'd652;
            5'd21: a = 32'd326;
            5'd22: a = 32'd163;
            5'd23: a = 32'd81;
            5'd24: a = 32'd41;
            5'd25: a = 32'd20;
            5'd26: a = 32'd10;
            5'd27: a = 32'd5;
            5'd28: a = 32'd3;
            5'd29: a = 32'd1;
            5'd30: a = 32'd1;
            default: a = 32'd0;
        endcase
        return a;
    endfunction

endpackage

// ===== hw/rtl/c2s_sqrt_cell.sv =====
// one step of the integer square root chain, one result bit per cell
// depends on c2s_pkg
module c2s_sqrt_cell (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic [4:0]          i_shift,
    input  logic                i_valid,
    input  c2s_pkg::t_sqrt_word i_word,
    output logic                o_valid,
    output c2s_pkg::t_sqrt_word o_word
);
    logic                r_valid;
    c2s_pkg::t_sqrt_word r_word;
    c2s_pkg::t_sqrt_word n_word;
    logic [31:0]         bitv;
    logic [31:0]         sum;

    always_comb begin
        bitv = 32'd1 << i_shift;
        sum = i_word.res + bitv;
        n_word = i_word;
        if (i_word.v >= sum) begin
            n_word.v = i_word.v - sum;
            n_word.res = (i_word.res >> 1) + bitv;
        end else begin
            n_word.res = i_word.res >> 1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
        r_word <= n_word;
    end

    assign o_valid = r_valid;
    assign o_word = r_word;
endmodule

// ===== hw/rtl/c2s_cordic_cell.sv =====
// one vectoring micro-rotation for the longitude and latitude lanes
// depends on c2s_pkg
module c2s_cordic_cell (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic [4:0]            i_stage,
    input  logic                  i_valid,
    input  c2s_pkg::t_cordic_word i_word,
    output logic                  o_valid,
    output c2s_pkg::t_cordic_word o_word
);
    logic                  r_valid;
    c2s_pkg::t_cordic_word r_word;
    c2s_pkg::t_cordic_word n_word;
    logic [31:0]           ang;

    always_comb begin
        ang = c2s_pkg::atan_turn(i_stage);
        n_word = i_word;
        if (!i_word.ly[c2s_pkg::CW-1]) begin
            n_word.lx = i_word.lx + (i_word.ly >>> i_stage);
            n_word.ly = i_word.ly - (i_word.lx >>> i_stage);
            n_word.lacc = i_word.lacc + ang;
        end else begin
            n_word.lx = i_word.lx - (i_word.ly >>> i_stage);
            n_word.ly = i_word.ly + (i_word.lx >>> i_stage);
            n_word.lacc = i_word.lacc - ang;
        end
        if (!i_word.by[c2s_pkg::CW-1]) begin
            n_word.bx = i_word.bx + (i_word.by >>> i_stage);
            n_word.by = i_word.by - (i_word.bx >>> i_stage);
            n_word.bacc = i_word.bacc + ang;
        end else begin
            n_word.bx = i_word.bx - (i_word.by >>> i_stage);
            n_word.by = i_word.by + (i_word.bx >>> i_stage);
            n_word.bacc = i_word.bacc - ang;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
        r_word <= n_word;
    end

    assign o_valid = r_valid;
    assign o_word = r_word;
endmodule

// ===== hw/rtl/cartesian_to_spherical_unit.sv =====
// top level of the cartesian to spherical unit: input stage, square root chain,
// cordic chain and output rounding; depends on c2s_pkg, c2s_sqrt_cell, c2s_cordic_cell
//
// usage
//   a word (x, y, z in Q2.14) is taken at a rising edge with start high and
//   busy low; busy is always low, so a word may be given every cycle
//   the result (longitude, latitude in turn units) appears on o_longitude and
//   o_latitude for exactly one cycle, marked by o_valid
//   a word passes the input register, one square root cell per result bit,
//   one cordic cell per micro-rotation and the output register
//   throughput: one word per cycle, every cell hands its word on each cycle
//   reset clears all valid flags; words in flight are dropped
//   the receiver cannot stall, results are not held
module cartesian_to_spherical_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic signed [15:0] i_x_coord,
    input  logic signed [15:0] i_y_coord,
    input  logic signed [15:0] i_z_coord,
    output logic               o_valid,
    output logic [15:0]        o_longitude,
    output logic signed [15:0] o_latitude
);
    localparam int CW = c2s_pkg::CW;
    localparam int NS = c2s_pkg::SQRT_STEPS;
    localparam int NR = c2s_pkg::NUM_ROT;

    logic                  r_in_valid;
    c2s_pkg::t_sqrt_word   r_in_word;
    c2s_pkg::t_sqrt_word   n_in_word;
    logic signed [16:0]    xs, ys, zs;
    logic signed [33:0]    zz;

    logic                  sq_valid [NS+1];
    c2s_pkg::t_sqrt_word   sq_word  [NS+1];
    logic                  co_valid [NR+1];
    c2s_pkg::t_cordic_word co_word  [NR+1];

    logic                  r_valid;
    logic [15:0]           r_lon;
    logic [15:0]           r_lat;
    logic [31:0]           lon_r, lat_r;

    assign busy = 1'b0;

    always_comb begin
        xs = 17'(i_x_coord);
        ys = 17'(i_y_coord);
        zs = 17'(i_z_coord);
        if (zs > 17'sd16384) zs = 17'sd16384;
        if (zs < -17'sd16384) zs = -17'sd16384;
        zz = zs * zs;
        n_in_word.lzero = (xs == 17'sd0) && (ys == 17'sd0);
        n_in_word.lacc = 32'd0;
        if (xs < 17'sd0) begin
            xs = -xs;
            ys = -ys;
            n_in_word.lacc = 32'h8000_0000;
        end
        n_in_word.lx = CW'(xs) <<< 16;
        n_in_word.ly = CW'(ys) <<< 16;
        n_in_word.v = 32'd268435456 - 32'(zz);
        n_in_word.res = 32'd0;
        n_in_word.z = zs;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= start && !busy;
        end
        r_in_word <= n_in_word;
    end

    assign sq_valid[0] = r_in_valid;
    assign sq_word[0] = r_in_word;

    for (genvar k = 0; k < NS; k++) begin : g_sqrt
        c2s_sqrt_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_shift (5'(2 * (NS - 1 - k))),
            .i_valid (sq_valid[k]),
            .i_word  (sq_word[k]),
            .o_valid (sq_valid[k+1]),
            .o_word  (sq_word[k+1])
        );
    end

    always_comb begin
        co_valid[0] = sq_valid[NS];
        co_word[0].lx = sq_word[NS].lx;
        co_word[0].ly = sq_word[NS].ly;
        co_word[0].lacc = sq_word[NS].lacc;
        co_word[0].lzero = sq_word[NS].lzero;
        co_word[0].bx = CW'(sq_word[NS].res) <<< 16;
        co_word[0].by = CW'(sq_word[NS].z) <<< 16;
        co_word[0].bacc = 32'd0;
    end

    for (genvar i = 0; i < NR; i++) begin : g_cordic
        c2s_cordic_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_stage (5'(i)),
            .i_valid (co_valid[i]),
            .i_word  (co_word[i]),
            .o_valid (co_valid[i+1]),
            .o_word  (co_word[i+1])
        );
    end

    assign lon_r = co_word[NR].lacc + 32'h0000_8000;
    assign lat_r = co_word[NR].bacc + 32'h0000_8000;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= co_valid[NR];
        end
        r_lon <= co_word[NR].lzero ? 16'd0 : lon_r[31:16];
        r_lat <= lat_r[31:16];
    end

    assign o_valid = r_valid;
    assign o_longitude = r_lon;
    assign o_latitude = r_lat;
endmodule

// ===== hw/rtl/c2s_checker.sv =====
// port-level checks of the cartesian to spherical unit, bound to the top level
// depends on c2s_pkg and cartesian_to_spherical_unit
module c2s_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               start,
    input logic               busy,
    input logic signed [15:0] i_x_coord,
    input logic signed [15:0] i_y_coord,
    input logic               o_valid,
    input logic [15:0]        o_longitude,
    input logic signed [15:0] o_latitude
);
    localparam int LAT = c2s_pkg::LATENCY;

    a_never_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !busy) else $error("busy raised");

    a_valid_has_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start && !busy, LAT)) else $error("result without word");

    a_lat_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_latitude <= 16'sd16384) && (o_latitude >= -16'sd16384))
        else $error("latitude out of range");

    a_origin_lon: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && $past(i_x_coord == 16'sd0 && i_y_coord == 16'sd0, LAT)
        |-> o_longitude == 16'd0) else $error("origin longitude not zero");
endmodule

bind cartesian_to_spherical_unit c2s_checker u_c2s_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .start       (start),
    .busy        (busy),
    .i_x_coord   (i_x_coord),
    .i_y_coord   (i_y_coord),
    .o_valid     (o_valid),
    .o_longitude (o_longitude),
    .o_latitude  (o_latitude)
);

// ===== test/cartesian_to_spherical_unit_chk.sv =====
// checker of the cartesian to spherical unit: predicts longitude and latitude
// of every accepted word and compares them with the result words; depends on c2s_pkg
`timescale 1ns / 100ps

module cartesian_to_spherical_unit_chk (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    input  logic               busy,
    input  logic signed [15:0] i_x_coord,
    input  logic signed [15:0] i_y_coord,
    input  logic signed [15:0] i_z_coord,
    input  logic               o_valid,
    input  logic [15:0]        o_longitude,
    input  logic signed [15:0] o_latitude,
    output int                 errors,
    output int                 pending
);
    localparam logic [31:0] HALF_TURN = 32'h8000_0000;
    localparam logic signed [31:0] ONE_Q14 = 32'sd16384;

    typedef struct packed {
        logic [15:0]        lon;
        logic signed [15:0] lat;
    } t_angles;

    t_angles angle_q[$];

    function automatic logic signed [63:0] floor_shift(logic signed [63:0] v, int s);
        return v >>> s;
    endfunction

    function automatic logic [31:0] vector_angle(logic signed [63:0] vx,
                                                 logic signed [63:0] vy,
                                                 logic [31:0] acc);
        logic signed [63:0] dx;
        logic signed [63:0] dy;
        logic [31:0] tab [32];
        tab = '{536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
                10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886,
                83443, 41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163,
                81, 41, 20, 10, 5, 3, 1, 1, 0};
        for (int i = 0; i < c2s_pkg::NUM_ROT; i++) begin
            dx = floor_shift(vy, i);
            dy = floor_shift(vx, i);
            if (vy >= 0) begin
                vx = vx + dx;
                vy = vy - dy;
                acc = acc + tab[i];
            end else begin
                vx = vx - dx;
                vy = vy + dy;
                acc = acc - tab[i];
            end
        end
        return acc;
    endfunction

    function automatic logic [31:0] int_sqrt(logic [31:0] v);
        logic [31:0] r;
        logic [31:0] b;
        r = 0;
        b = 32'h4000_0000;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic t_angles to_spherical(logic signed [15:0] xi,
                                             logic signed [15:0] yi,
                                             logic signed [15:0] zi);
        logic signed [63:0] x;
        logic signed [63:0] y;
        logic signed [63:0] z;
        logic [31:0] lon_acc;
        logic [31:0] lat_acc;
        logic [31:0] base;
        logic [31:0] c;
        t_angles a;
        x = xi;
        y = yi;
        z = zi;
        lon_acc = 0;
        if (x != 0 || y != 0) begin
            base = 0;
            if (x < 0) begin
                x = -x;
                y = -y;
                base = HALF_TURN;
            end
            lon_acc = vector_angle(x * 65536, y * 65536, base);
        end
        if (z > ONE_Q14) z = ONE_Q14;
        if (z < -ONE_Q14) z = -ONE_Q14;
        c = int_sqrt(32'(64'sd268435456 - z * z));
        lat_acc = vector_angle(64'(c) * 65536, z * 65536, 0);
        lon_acc = lon_acc + 32'h8000;
        lat_acc = lat_acc + 32'h8000;
        a.lon = (x == 0 && y == 0) ? 16'd0 : lon_acc[31:16];
        a.lat = lat_acc[31:16];
        return a;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
        errors++;
    endtask

    initial errors = 0;

    always @(posedge i_clk) begin
        t_angles w;
        if (i_rst_n && o_valid) begin
            if (angle_q.size() == 0) begin
                report_mismatch("unexpected word", o_longitude, -1);
            end else begin
                w = angle_q.pop_front();
                if (o_longitude !== w.lon) report_mismatch("longitude", o_longitude, w.lon);
                if (o_latitude !== w.lat) report_mismatch("latitude", o_latitude, w.lat);
            end
        end
        if (i_rst_n && start && !busy)
            angle_q.push_back(to_spherical(i_x_coord, i_y_coord, i_z_coord));
        pending <= angle_q.size();
    end
endmodule

// ===== test/cartesian_to_spherical_unit_tb.sv =====
// testbench top of the cartesian to spherical unit: clock, reset, directed and
// random coordinate words; depends on c2s_pkg, the unit and its checker
`timescale 1ns / 100ps

module cartesian_to_spherical_unit_tb;
    localparam int LIMIT = 200000;

    logic               i_clk = 0;
    logic               i_rst_n = 0;
    logic               start = 0;
    logic               busy;
    logic signed [15:0] i_x_coord = 0;
    logic signed [15:0] i_y_coord = 0;
    logic signed [15:0] i_z_coord = 0;
    logic               o_valid;
    logic [15:0]        o_longitude;
    logic signed [15:0] o_latitude;
    int                 errors;
    int                 pending;
    int                 cycles = 0;
    int                 idle_pct = 0;

    always begin
        #6 i_clk = 1;
        #6 i_clk = 0;
    end

    cartesian_to_spherical_unit uut (.*);

    cartesian_to_spherical_unit_chk chk (.*);

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("cartesian_to_spherical_unit test failed");
            $finish;
        end
    end

    function automatic logic signed [15:0] rand_coord();
        case ($urandom_range(0, 5))
            0: return 16'($urandom);
            1: return 16'sd16384;
            2: return -16'sd16384;
            3: return 16'($signed($urandom_range(0, 8)) - 4);
            default: return 16'($signed($urandom_range(0, 32768)) - 16384);
        endcase
    endfunction

    task automatic send_word(logic signed [15:0] x, logic signed [15:0] y,
                             logic signed [15:0] z);
        while ($urandom_range(0, 99) < idle_pct) begin
            start <= 0;
            @(posedge i_clk);
        end
        start <= 1;
        i_x_coord <= x;
        i_y_coord <= y;
        i_z_coord <= z;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    initial begin
        logic signed [15:0] dir [9];
        dir = '{0, 1, -1, 16384, -16384, 11585, -11585, 16'sh7fff, 16'sh8000};
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);
        for (int k = 0; k < 25; k++)
            send_word(dir[k % 9], dir[(k * 4 + 1) % 9], dir[(k * 2 + 3) % 9]);
        start <= 0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        for (int ph = 0; ph < 4; ph++) begin
            idle_pct = (ph == 1) ? 85 : (ph == 3) ? 8 : 0;
            for (int k = 0; k < 170; k++)
                send_word(rand_coord(), rand_coord(), rand_coord());
        end
        start <= 0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (c2s_pkg::LATENCY + 4) @(posedge i_clk);
        if (errors == 0 && pending == 0)
            $display("cartesian_to_spherical_unit test passed");
        else
            $display("cartesian_to_spherical_unit test failed");
        $finish;
    end
endmodule
